// ===== src/tzs_pkg.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stepper package
// Shared payload types, option bit positions and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package tzs_pkg;
    localparam int unsigned REG_COUNT = 7;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 31;

    localparam logic [CFG_IDX_BITS-1:0] REG_RATE_MAX    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE_MIN    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE_HOMING = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_STEPS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TICK_PERIOD = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRAVEL_LIM  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_OPTIONS     = 3'd6;

    localparam int unsigned OPT_HOME_UP   = 0;
    localparam int unsigned OPT_SWAP      = 1;
    localparam int unsigned OPT_LEVEL     = 2;
    localparam int unsigned OPT_STOPS_EN  = 3;
    localparam int unsigned OPT_CLAMP_HOME = 4;
    localparam int unsigned OPT_CLAMP_MAX = 5;
    localparam int unsigned OPT_INVERT    = 6;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CRAWL  = 3'd1;
    localparam logic [2:0] PH_ACCEL  = 3'd2;
    localparam logic [2:0] PH_CRUISE = 3'd3;
    localparam logic [2:0] PH_DECEL  = 3'd4;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] move_source;
        logic signed [31:0] move_target;
        logic               home_request;
        logic               limit_min_raw;
        logic               limit_max_raw;
    } t_in_item;

    typedef struct packed {
        logic               step_pulse;
        logic               direction_level;
        logic signed [31:0] position;
        logic               axis_busy;
        logic [2:0]         motion_phase;
        logic [15:0]        step_rate;
        logic               target_clamped;
        logic               step_completed;
    } t_out_item;

    // Serial divider handshake.
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

// ===== src/tzs_if.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stepper item channel
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface tzs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/tzs_div.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stepper serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tzs_div import tzs_pkg::*; #(
    parameter int unsigned W = 48
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic              o_done,
    output logic [W-1:0]      o_quo
);
    localparam int unsigned CW = $clog2(W + 1);
    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic [W:0]    w_sh;
    logic [W:0]    w_sub;

    assign w_sh  = {r_rem[W-1:0], r_q[W-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_q   <= i_num;
                r_d   <= i_den;
                r_rem <= '0;
                r_cnt <= CW'(W);
            end else if (r_run) begin
                if (!w_sub[W]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
endmodule
`default_nettype wire

// ===== src/tzs_mul.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stepper serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tzs_mul #(
    parameter int unsigned AW = 32,
    parameter int unsigned BW = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic                  o_done,
    output logic [AW+BW-1:0]      o_prod
);
    localparam int unsigned CW = $clog2(BW + 1);
    logic [AW+BW-1:0] r_a;
    logic [BW-1:0]    r_b;
    logic [CW-1:0]    r_cnt;
    logic             r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_a    <= {{BW{1'b0}}, i_a};
                r_b    <= i_b;
                o_prod <= '0;
                r_cnt  <= CW'(BW);
            end else if (r_run) begin
                if (r_b[0]) o_prod <= o_prod + r_a;
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/stepper_axis_trapezoid_stepper.sv =====
// ----------------------------------------------------------------------------
// Trapezoidal stepper axis
// Load and tick items drive a trapezoid step profile for one axis.
// ----------------------------------------------------------------------------
// One item at a time. A load item passes through S_DIR and S_OUT. A tick
// item passes through S_DIR, S_CTRL, S_PULSE and S_OUT; when the ramp is
// active it adds one serial multiply and one serial divide, and on a falling
// step edge it adds a multiply of period by rate and two divides. The shared
// shift-and-add multiplier and restoring divider carry out this arithmetic.
`default_nettype none
module stepper_axis_trapezoid_stepper import tzs_pkg::*; #(
    parameter int unsigned POSITION_BITS = 32,
    parameter int unsigned RATE_BITS     = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    tzs_if.sink                           s_in,
    tzs_if.source                         m_out
);
    localparam int unsigned PB = POSITION_BITS;
    localparam int unsigned RB = RATE_BITS;
    localparam int unsigned MW = PB + RB + 1;   // ramp product width
    localparam int unsigned DW = 48;            // shared divider width
    localparam logic [RB-1:0] RTOP = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIR, S_CTRL, S_RMUL, S_RMULW, S_RDIV, S_RDIVW, S_PULSE,
        S_EMUL, S_EMULW, S_EDIV1, S_EDIV1W, S_EDIV2, S_EDIV2W, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_rmax, r_rmin, r_rhom;
    logic [30:0] r_ramp, r_lim;
    logic [9:0]  r_per;
    logic [6:0]  r_opt;
    t_in_item    r_in;
    logic [31:0] r_tick, r_rise, r_fall;
    logic        r_pulse, r_busy, r_homing, r_up, r_th, r_clamped, r_stepped;
    logic signed [PB-1:0] r_start, r_cur, r_end;
    logic [RB-1:0] r_rate;
    logic [2:0]    r_phase;
    logic          r_valid;
    t_out_item     r_out;
    logic          r_dn;        // ramp decreasing
    logic [PB:0]   r_d;         // ramp distance
    logic [DW-1:0] r_den;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmax <= 16'd1000; r_rmin <= 16'd100; r_rhom <= 16'd50;
            r_ramp <= 31'd500;  r_per  <= 10'd40;  r_lim  <= '0; r_opt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RATE_MAX:    r_rmax <= i_cfg_data[15:0];
                REG_RATE_MIN:    r_rmin <= i_cfg_data[15:0];
                REG_RATE_HOMING: r_rhom <= i_cfg_data[15:0];
                REG_RAMP_STEPS:  r_ramp <= i_cfg_data;
                REG_TICK_PERIOD: r_per  <= i_cfg_data[9:0];
                REG_TRAVEL_LIM:  r_lim  <= i_cfg_data;
                REG_OPTIONS:     r_opt  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    function automatic logic [RB-1:0] sat(input logic [17:0] v);
        sat = ({{(RB > 18 ? RB-18 : 0){1'b0}}, v} > {{(RB < 18 ? 18-RB : 0){1'b0}}, RTOP})
            ? RTOP : RB'(v);
    endfunction

    // end stop sense
    logic w_mn, w_mx, w_stop_min, w_stop_max;
    always_comb begin
        w_mn = r_opt[OPT_STOPS_EN] && (r_in.limit_min_raw == r_opt[OPT_LEVEL]);
        w_mx = r_opt[OPT_STOPS_EN] && (r_in.limit_max_raw == r_opt[OPT_LEVEL]);
        w_stop_min = r_opt[OPT_SWAP] ? w_mx : w_mn;
        w_stop_max = r_opt[OPT_SWAP] ? w_mn : w_mx;
    end

    // load clamp (34-bit signed domain on 32-bit target)
    logic signed [33:0] w_tgt0, w_tgt1, w_mag;
    logic               w_cl0, w_cl1;
    always_comb begin
        w_tgt0 = 34'(r_in.move_target);
        w_cl0  = 1'b0;
        if (r_opt[OPT_CLAMP_HOME] &&
            ((!r_opt[OPT_HOME_UP] && w_tgt0 < 0) || (r_opt[OPT_HOME_UP] && w_tgt0 > 0))) begin
            w_tgt0 = '0; w_cl0 = 1'b1;
        end
        w_mag  = (w_tgt0 < 0) ? -w_tgt0 : w_tgt0;
        w_tgt1 = w_tgt0;
        w_cl1  = w_cl0;
        if (r_lim != 0 && r_opt[OPT_CLAMP_MAX] && w_mag > $signed({3'b0, r_lim})) begin
            w_tgt1 = (w_tgt0 < 0) ? -$signed({3'b0, r_lim}) : $signed({3'b0, r_lim});
            w_cl1  = 1'b1;
        end
    end

    // rate geometry
    logic signed [PB+1:0] w_span, w_off, w_steps, w_half;
    always_comb begin
        w_span  = (r_end > r_start) ? (PB+2)'(r_end) - (PB+2)'(r_start)
                                    : (PB+2)'(r_start) - (PB+2)'(r_end);
        w_off   = (r_start < r_end) ? (PB+2)'(r_cur) - (PB+2)'(r_start)
                                    : (PB+2)'(r_cur) - (PB+2)'(r_end);
        w_steps = $signed((PB+2)'({1'b0, r_ramp}));
        w_half  = w_span >>> 1;
    end

    logic signed [PB:0] w_ac, w_ae;
    assign w_ac = (r_cur < 0) ? -(PB+1)'(r_cur) : (PB+1)'(r_cur);
    assign w_ae = (r_end < 0) ? -(PB+1)'(r_end) : (PB+1)'(r_end);

    // shared serial units
    logic          w_mstart, w_mdone, w_dstart, w_ddone;
    logic [PB:0]   w_ma;
    logic [RB-1:0] w_mb;
    logic [PB+RB:0] w_prod;
    logic [DW-1:0] w_num, w_dden, w_quo;
    logic [RB-1:0] w_rdiff, w_redge;

    assign w_rdiff = r_dn ? RB'(r_rmin - r_rmax) : RB'(r_rmax - r_rmin);
    assign w_redge = (r_rate != 0) ? r_rate : sat({2'b0, r_rmin});
    assign w_mstart = (r_state == S_RMUL) || (r_state == S_EMUL);
    assign w_ma = (r_state == S_EMUL) ? (PB+1)'(r_per) : r_d;
    assign w_mb = (r_state == S_EMUL) ? w_redge : w_rdiff;
    assign w_dstart = (r_state == S_RDIV) || (r_state == S_EDIV1) || (r_state == S_EDIV2);

    logic [DW-1:0] w_rnum;
    assign w_rnum = DW'(w_prod) + (r_dn ? DW'(r_ramp) - 1'b1 : '0);
    always_comb begin
        unique case (r_state)
            S_EDIV1: begin w_num = DW'(500000);  w_dden = r_den; end
            S_EDIV2: begin w_num = DW'(1000000); w_dden = r_den; end
            default: begin w_num = w_rnum;       w_dden = DW'(r_ramp); end
        endcase
    end

    tzs_mul #(.AW(PB+1), .BW(RB)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_prod(w_prod)
    );
    tzs_div #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_num), .i_den(w_dden), .o_done(w_ddone), .o_quo(w_quo)
    );

    logic [32:0] w_edge;
    assign w_edge = (r_den == 0 || |w_quo[DW-1:32]) ? 33'h0_FFFF_FFFF
                  : {1'b0, r_tick} + {1'b0, w_quo[31:0]};
    logic [31:0] w_edge_sat;
    assign w_edge_sat = w_edge[32] ? 32'hFFFF_FFFF : w_edge[31:0];

    logic [RB+1:0] w_ramp_r;
    always_comb begin
        if (r_dn) w_ramp_r = (RB+2)'(r_rmin) - (RB+2)'(w_quo);
        else      w_ramp_r = (RB+2)'(r_rmin) + (RB+2)'(w_quo);
    end

    assign s_in.ready = (r_state == S_IDLE) && !r_valid;
    assign m_out.valid = r_valid;
    assign m_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0;
            r_tick <= '0; r_rise <= '0; r_fall <= '0;
            r_pulse <= 1'b0; r_busy <= 1'b0; r_homing <= 1'b0;
            r_up <= 1'b0; r_th <= 1'b0;
            r_start <= '0; r_cur <= '0; r_end <= '0;
            r_rate <= '0; r_phase <= PH_IDLE;
            r_clamped <= 1'b0; r_stepped <= 1'b0; r_dn <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_in.valid && s_in.ready) begin
                    r_in <= s_in.data;
                    r_clamped <= 1'b0; r_stepped <= 1'b0;
                    r_state <= S_DIR;
                end
                S_DIR: begin
                    if (r_in.kind) begin
                        r_start <= PB'(r_in.move_source);
                        r_cur   <= PB'(r_in.move_source);
                        r_homing <= r_in.home_request;
                        r_end   <= PB'(w_tgt1);
                        r_clamped <= w_cl1;
                        r_tick <= '0;
                        r_busy <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        if (r_busy) r_tick <= r_tick + 1'b1;
                        if (r_homing) begin
                            r_up <= r_opt[OPT_HOME_UP]; r_th <= 1'b1;
                        end else begin
                            r_up <= r_cur < r_end; r_th <= w_ac >= w_ae;
                        end
                        if (r_cur == 0) r_rate <= sat({2'b0, r_rmin});
                        r_state <= S_CTRL;
                    end
                end
                S_CTRL: begin
                    r_state <= S_PULSE;
                    if (r_busy && ((r_end > r_start && r_cur < r_end) ||
                                   (r_end < r_start && r_cur > r_end) || r_homing)) begin
                        if ((r_homing || r_th) ? w_stop_min : w_stop_max) begin
                            r_busy <= 1'b0; r_phase <= PH_IDLE;
                        end else if (w_off < 0 || w_off > w_span) begin
                            r_phase <= PH_CRAWL; r_rate <= sat({2'b0, r_rhom});
                        end else if (w_off <= w_half) begin
                            if (w_off > w_steps) begin
                                r_phase <= PH_CRUISE;
                                r_rate <= sat({2'b0, r_rmax} + 18'd1);
                            end else begin
                                r_phase <= PH_ACCEL;
                                r_d <= (PB+1)'(w_off);
                                r_state <= S_RMUL;
                            end
                        end else if (w_off < w_span - w_steps) begin
                            r_phase <= PH_CRUISE;
                            r_rate <= sat({2'b0, r_rmax} + 18'd2);
                        end else begin
                            r_phase <= PH_DECEL;
                            r_d <= (PB+1)'(w_span - w_off);
                            r_state <= S_RMUL;
                        end
                    end else begin
                        r_busy <= 1'b0; r_phase <= PH_IDLE;
                    end
                    r_dn <= r_rmax < r_rmin;
                end
                S_RMUL: r_state <= (r_ramp == 0) ? S_PULSE : S_RMULW;
                S_RMULW: if (w_mdone) r_state <= S_RDIV;
                S_RDIV: r_state <= S_RDIVW;
                S_RDIVW: if (w_ddone) begin
                    r_rate <= sat(w_ramp_r[17:0] | (|w_ramp_r[RB+1:(RB>18?18:RB)] ? 18'h3FFFF : '0));
                    r_state <= S_PULSE;
                end
                S_PULSE: begin
                    r_state <= S_OUT;
                    if (r_phase == PH_ACCEL || r_phase == PH_DECEL)
                        if (r_ramp == 0) r_rate <= sat({2'b0, r_rmin});
                    if (w_stop_min) r_cur <= '0;
                    if (r_pulse) begin
                        if (r_tick >= r_fall) begin
                            r_pulse <= 1'b0; r_stepped <= 1'b1;
                            r_state <= S_EMUL;
                        end
                    end else if (r_busy && r_tick >= r_rise) begin
                        r_pulse <= 1'b1;
                        r_cur <= r_up ? (w_stop_min ? PB'(1) : r_cur + 1'b1)
                                      : (w_stop_min ? '1 : r_cur - 1'b1);
                    end
                end
                S_EMUL: r_state <= S_EMULW;
                S_EMULW: if (w_mdone) begin
                    r_den <= DW'(w_prod); r_state <= S_EDIV1;
                end
                S_EDIV1: r_state <= S_EDIV1W;
                S_EDIV1W: if (w_ddone) begin
                    r_rise <= w_edge_sat; r_state <= S_EDIV2;
                end
                S_EDIV2: r_state <= S_EDIV2W;
                S_EDIV2W: if (w_ddone) begin
                    r_fall <= w_edge_sat; r_state <= S_OUT;
                end
                S_OUT: if (!r_valid) begin
                    r_out.step_pulse      <= r_pulse;
                    r_out.direction_level <= r_up ^ r_opt[OPT_INVERT];
                    r_out.position        <= 32'(r_cur);
                    r_out.axis_busy       <= r_busy;
                    r_out.motion_phase    <= r_phase;
                    r_out.step_rate       <= 16'(r_rate);
                    r_out.target_clamped  <= r_clamped;
                    r_out.step_completed  <= r_stepped;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/tzs_checker.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stepper port checker
// Watches the top level's ports for profile and handshake sanity.
// ----------------------------------------------------------------------------
`default_nettype none
module tzs_checker import tzs_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire t_out_item out_data
);
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.axis_busy |-> out_data.motion_phase == PH_IDLE)
        else $error("idle axis shows motion phase");
    // one item at a time: the block is busy right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready again right after an item");
    a_step_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.step_completed |-> !out_data.step_pulse)
        else $error("completed step with pulse high");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted while result pending");
endmodule

bind stepper_axis_trapezoid_stepper tzs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_data(m_out.data)
);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trapezoid stepper axis testbench
// Drives load and tick items through the valid/ready channel under random
// idling on both sides. A predictor models the axis state and works out the
// output item for each accepted input item. Results are checked field by
// field. The run steps through several register settings, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    import tzs_pkg::*;

    localparam longint unsigned TICK_MAX = 64'hFFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 50000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    tzs_if #(.T(t_in_item))  in_ch ();
    tzs_if #(.T(t_out_item)) out_ch ();

    stepper_axis_trapezoid_stepper DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    longint unsigned reg_val [REG_COUNT];
    longint unsigned ticks, rise_at, fall_at, rate_cur;
    logic            pulse_on, moving, seek_home, going_up, near_home;
    longint          from_pos, cur_pos, to_pos;
    logic [2:0]      phase_cur;

    t_in_item  pending_items [$];
    t_out_item axis_expected [$];
    int        errors = 0;
    int        idle_cycles = 0;
    logic      no_idle = 1'b0;
    logic      hold_go = 1'b0;
    int        hold_left = 0;

    function automatic longint wrap_pos(longint v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic longint unsigned sat_rate(longint unsigned r);
        return (r > 65535) ? 65535 : r;
    endfunction

    function automatic logic opt_on(int unsigned b);
        return reg_val[REG_OPTIONS][b];
    endfunction

    function automatic logic end_stop(logic fwd, logic raw_min, logic raw_max);
        logic mn, mx, t;
        mn = opt_on(OPT_STOPS_EN) && (raw_min == opt_on(OPT_LEVEL));
        mx = opt_on(OPT_STOPS_EN) && (raw_max == opt_on(OPT_LEVEL));
        if (opt_on(OPT_SWAP)) begin
            t = mn; mn = mx; mx = t;
        end
        return fwd ? mx : mn;
    endfunction

    function automatic longint unsigned ramp(longint unsigned d, longint unsigned n);
        longint unsigned lo, hi;
        lo = reg_val[REG_RATE_MIN];
        hi = reg_val[REG_RATE_MAX];
        if (n == 0) return sat_rate(lo);
        if (hi >= lo) return sat_rate(lo + (d * (hi - lo)) / n);
        return sat_rate(lo - (d * (lo - hi) + n - 1) / n);
    endfunction

    function automatic longint unsigned profile_rate();
        longint span, off, n, half;
        span = (to_pos > from_pos) ? to_pos - from_pos : from_pos - to_pos;
        off  = (from_pos < to_pos) ? cur_pos - from_pos : cur_pos - to_pos;
        n    = longint'(reg_val[REG_RAMP_STEPS]);
        half = span / 2;
        if (off < 0 || off > span) begin
            phase_cur = PH_CRAWL;
            return sat_rate(reg_val[REG_RATE_HOMING]);
        end
        if (off <= half) begin
            if (off > n) begin
                phase_cur = PH_CRUISE;
                return sat_rate(reg_val[REG_RATE_MAX] + 1);
            end
            phase_cur = PH_ACCEL;
            return ramp(off, n);
        end
        if (off < span - n) begin
            phase_cur = PH_CRUISE;
            return sat_rate(reg_val[REG_RATE_MAX] + 2);
        end
        phase_cur = PH_DECEL;
        return ramp(span - off, n);
    endfunction

    function automatic longint unsigned edge_tick(longint unsigned num, longint unsigned den);
        longint unsigned s;
        if (den == 0) return TICK_MAX;
        s = ticks + num / den;
        return (s > TICK_MAX) ? TICK_MAX : s;
    endfunction

    function automatic t_out_item axis_predict(t_in_item it);
        t_out_item r;
        logic clamped, stepped, hit;
        longint tgt, lim, mag, ac, ae;
        longint unsigned rr, den;
        clamped = 1'b0;
        stepped = 1'b0;
        if (it.kind) begin
            tgt = longint'(it.move_target);
            lim = longint'(reg_val[REG_TRAVEL_LIM]);
            from_pos = wrap_pos(longint'(it.move_source));
            cur_pos = from_pos;
            seek_home = it.home_request;
            if (opt_on(OPT_CLAMP_HOME)) begin
                if ((!opt_on(OPT_HOME_UP) && tgt < 0) || (opt_on(OPT_HOME_UP) && tgt > 0)) begin
                    tgt = 0;
                    clamped = 1'b1;
                end
            end
            if (lim > 0 && opt_on(OPT_CLAMP_MAX)) begin
                mag = (tgt < 0) ? -tgt : tgt;
                if (mag > lim) begin
                    tgt = (tgt < 0) ? -lim : lim;
                    clamped = 1'b1;
                end
            end
            to_pos = wrap_pos(tgt);
            ticks = 0;
            moving = 1'b1;
        end else begin
            if (moving) ticks = (ticks + 1) & TICK_MAX;
            if (seek_home) begin
                going_up = opt_on(OPT_HOME_UP);
                near_home = 1'b1;
            end else begin
                ac = (cur_pos < 0) ? -cur_pos : cur_pos;
                ae = (to_pos < 0) ? -to_pos : to_pos;
                going_up = cur_pos < to_pos;
                near_home = ac >= ae;
            end
            // sitting at zero restarts from the low rate
            if (cur_pos == 0) rate_cur = sat_rate(reg_val[REG_RATE_MIN]);
            if (moving && ((to_pos > from_pos && cur_pos < to_pos) ||
                           (to_pos < from_pos && cur_pos > to_pos) || seek_home)) begin
                hit = seek_home ? end_stop(1'b0, it.limit_min_raw, it.limit_max_raw)
                                : end_stop(!near_home, it.limit_min_raw, it.limit_max_raw);
                if (!hit) rate_cur = profile_rate();
                else moving = 1'b0;
            end else begin
                moving = 1'b0;
            end
            if (!moving) phase_cur = PH_IDLE;
            if (end_stop(1'b0, it.limit_min_raw, it.limit_max_raw)) cur_pos = 0;
            if (pulse_on) begin
                if (ticks >= fall_at) begin
                    rr = (rate_cur != 0) ? rate_cur : sat_rate(reg_val[REG_RATE_MIN]);
                    den = reg_val[REG_TICK_PERIOD] * rr;
                    pulse_on = 1'b0;
                    stepped = 1'b1;
                    rise_at = edge_tick(500000, den);
                    fall_at = edge_tick(1000000, den);
                end
            end else if (moving && ticks >= rise_at) begin
                pulse_on = 1'b1;
                cur_pos = going_up ? wrap_pos(cur_pos + 1) : wrap_pos(cur_pos - 1);
            end
        end
        r.step_pulse      = pulse_on;
        r.direction_level = going_up ^ opt_on(OPT_INVERT);
        r.position        = cur_pos[31:0];
        r.axis_busy       = moving;
        r.motion_phase    = phase_cur;
        r.step_rate       = rate_cur[15:0];
        r.target_clamped  = clamped;
        r.step_completed  = stepped;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                axis_expected.push_back(axis_predict(in_ch.data));
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_ch.data  <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor
    int take_gap = 0;
    always @(posedge i_clk) begin
        t_out_item e, a;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = 2000;
            end
            if (out_ch.valid && out_ch.ready) begin
                a = out_ch.data;
                if (axis_expected.size() == 0) begin
                    $error("result with no expected item pending");
                    errors++;
                end else begin
                    e = axis_expected.pop_front();
                    check_field("step_pulse", e.step_pulse, a.step_pulse);
                    check_field("direction_level", e.direction_level, a.direction_level);
                    check_field("position", e.position, a.position);
                    check_field("axis_busy", e.axis_busy, a.axis_busy);
                    check_field("motion_phase", e.motion_phase, a.motion_phase);
                    check_field("step_rate", e.step_rate, a.step_rate);
                    check_field("target_clamped", e.target_clamped, a.target_clamped);
                    check_field("step_completed", e.step_completed, a.step_completed);
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready) take_gap <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint unsigned v);
        longint unsigned w;
        case (idx)
            REG_RAMP_STEPS, REG_TRAVEL_LIM: w = v & 64'h7FFF_FFFF;
            REG_TICK_PERIOD:                w = v & 64'h3FF;
            REG_OPTIONS:                    w = v & 64'h7F;
            default:                        w = v & 64'hFFFF;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= w[CFG_DATA_BITS-1:0];
        reg_val[idx] = w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(longint unsigned mx, longint unsigned mn, longint unsigned hm,
                            longint unsigned rs, longint unsigned tp, longint unsigned tl,
                            longint unsigned op);
        write_reg(REG_RATE_MAX, mx);
        write_reg(REG_RATE_MIN, mn);
        write_reg(REG_RATE_HOMING, hm);
        write_reg(REG_RAMP_STEPS, rs);
        write_reg(REG_TICK_PERIOD, tp);
        write_reg(REG_TRAVEL_LIM, tl);
        write_reg(REG_OPTIONS, op);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || axis_expected.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_in_item tick_item(logic mn, logic mx);
        t_in_item it;
        it = '0;
        it.kind = 1'b0;
        it.move_source = $urandom;
        it.move_target = $urandom;
        it.home_request = $urandom_range(0, 1);
        it.limit_min_raw = mn;
        it.limit_max_raw = mx;
        return it;
    endfunction

    function automatic t_in_item load_item(int src, int tgt, logic home);
        t_in_item it;
        it = '0;
        it.kind = 1'b1;
        it.move_source = src;
        it.move_target = tgt;
        it.home_request = home;
        it.limit_min_raw = $urandom_range(0, 1);
        it.limit_max_raw = $urandom_range(0, 1);
        return it;
    endfunction

    // load plus a run of ticks; stops stay mostly inactive
    task automatic queue_move(ref int n);
        int src, tgt, len;
        logic quiet;
        quiet = !reg_val[REG_OPTIONS][OPT_LEVEL];
        if ($urandom_range(0, 9) == 0) begin
            src = $urandom;
            tgt = $urandom;
        end else begin
            src = $urandom_range(0, 100) - 50;
            tgt = src + $urandom_range(0, 80) - 40;
        end
        pending_items.push_back(load_item(src, tgt, $urandom_range(0, 7) == 0));
        n++;
        len = $urandom_range(5, 40);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 24) == 0)
                pending_items.push_back(tick_item($urandom_range(0, 1), $urandom_range(0, 1)));
            else
                pending_items.push_back(tick_item(quiet, quiet));
            n++;
        end
    endtask

    task automatic run_random(int count);
        int n;
        n = 0;
        while (n < count) queue_move(n);
    endtask

    initial begin
        int unsigned o;
        reg_val[REG_RATE_MAX] = 1000;
        reg_val[REG_RATE_MIN] = 100;
        reg_val[REG_RATE_HOMING] = 50;
        reg_val[REG_RAMP_STEPS] = 500;
        reg_val[REG_TICK_PERIOD] = 40;
        reg_val[REG_TRAVEL_LIM] = 0;
        reg_val[REG_OPTIONS] = 0;
        ticks = 0; rise_at = 0; fall_at = 0; rate_cur = 0;
        pulse_on = 0; moving = 0; seek_home = 0; going_up = 0; near_home = 0;
        from_pos = 0; cur_pos = 0; to_pos = 0; phase_cur = PH_IDLE;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle ticks, field extremes, homing, stop hits, clamps
        pending_items.push_back(tick_item(1'b0, 1'b0));
        pending_items.push_back(tick_item(1'b1, 1'b1));
        pending_items.push_back(load_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        pending_items.push_back(tick_item(1'b1, 1'b0));
        pending_items.push_back(load_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        pending_items.push_back(tick_item(1'b0, 1'b1));
        pending_items.push_back(load_item(0, 3, 1'b0));
        for (int k = 0; k < 4; k++) pending_items.push_back(tick_item(1'b1, 1'b1));
        pending_items.push_back(load_item(-1, -1, 1'b1));
        pending_items.push_back(tick_item(1'b0, 1'b0));
        drain();
        set_regs(5000, 1000, 2000, 3, 1000, 10, 8'h38);
        pending_items.push_back(load_item(5, -100, 1'b0));
        pending_items.push_back(load_item(-5, 100, 1'b0));
        for (int k = 0; k < 6; k++) pending_items.push_back(tick_item(1'b1, 1'b1));
        pending_items.push_back(load_item(0, 1, 1'b1));
        pending_items.push_back(tick_item(1'b1, 1'b1));
        pending_items.push_back(tick_item(1'b0, 1'b0));
        drain();

        set_regs(5000, 1000, 2000, 10, 1000, 0, 0);
        run_random(200);
        drain();

        // receiver holds off while the sender keeps offering
        set_regs(65533, 65535, 65535, 0, 1, 30, 8'h38);
        hold_go = 1'b1;
        run_random(150);
        drain();

        set_regs(0, 0, 0, 64'h7FFF_FFFF, 1000, 64'h7FFF_FFFF, 127);
        run_random(100);
        drain();

        no_idle = 1'b1;
        set_regs(3000, 60000, 500, 5, 500, 20, $urandom_range(0, 127));
        run_random(150);
        drain();
        no_idle = 1'b0;

        for (int p = 0; p < 4; p++) begin
            o = $urandom_range(0, 127);
            set_regs($urandom_range(1000, 65533), $urandom_range(500, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 20),
                     $urandom_range(200, 1000), $urandom_range(0, 60), o);
            run_random(100);
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
